/* rtl/core/pcs_pkg.sv */
// Shared constants, codes and types for the path corridor splice block.
`default_nettype none
package pcs_pkg;

   // Storage geometry
   localparam int CORR_DEPTH = 256;
   localparam int CORR_AW    = $clog2(CORR_DEPTH);
   localparam int CNT_W      = CORR_AW + 1;
   localparam int VIS_DEPTH  = 16;
   localparam int VIS_IW     = $clog2(VIS_DEPTH);
   localparam int VIS_CW     = VIS_IW + 1;

   // Field widths
   localparam int REF_W  = 32;
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 8;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 9;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND_CORR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_VIS  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SPLICE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // Register map
   localparam int                CSR_AW          = 2;
   localparam logic [CSR_AW-1:0] CSR_MAX_LEN     = 2'd0;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 9'd256;

   // Control for the visited cell chain
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* rtl/core/pcs_visit_cell.sv */
// One visited-list cell: holds a reference, shifts with its neighbors, compares a probe.
`default_nettype none
module pcs_visit_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pcs_pkg::cell_ctl_type     ctl,
   input  wire logic [pcs_pkg::REF_W-1:0] prev_value,
   input  wire logic                      prev_valid,
   input  wire logic [pcs_pkg::REF_W-1:0] next_value,
   input  wire logic                      next_valid,
   input  wire logic [pcs_pkg::REF_W-1:0] probe,
   output logic      [pcs_pkg::REF_W-1:0] value,
   output logic                           valid,
   output logic                           match
);

   logic [pcs_pkg::REF_W-1:0] value_ff;
   logic                      valid_ff;

   // Track occupancy: clear empties, push takes from below, pop takes from above
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.push) begin
         valid_ff <= prev_valid;
      end else if (ctl.pop) begin
         valid_ff <= next_valid;
      end
   end

   // Shift the stored reference
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         value_ff <= prev_value;
      end else if (ctl.pop) begin
         value_ff <= next_value;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (value_ff == probe);

endmodule
`default_nettype wire

/* rtl/core/path_corridor_splice_core.sv */
// Top level of the path corridor splice block: corridor memory, visited cell chain, sequencer.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | command, poly_ref, index
//  rsp     | out       | rsp_valid/rsp_stall | path_length, entry, found, status
//  csr     | in/out    | APB psel/penable    | max_path_len at byte address 0
//
// A splice scans corridor entries (a memory read, then a compare against all 16
// visited cells at once), moves corridor entries through the memory (a read, then a
// write), and writes the visited entries taken back into the corridor.
// One item is worked at a time; the next is taken while the previous result waits.
// Reset is synchronous; it empties both lists and needs no clearing pass.
`default_nettype none
module path_corridor_splice_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Item input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [pcs_pkg::CMD_W-1:0]          req_command,
   input  wire logic [pcs_pkg::REF_W-1:0]          req_poly_ref,
   input  wire logic [pcs_pkg::IDX_W-1:0]          req_index,
   // Result output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [pcs_pkg::LEN_W-1:0]          rsp_path_length,
   output logic      [pcs_pkg::REF_W-1:0]          rsp_entry,
   output logic                                    rsp_found,
   output logic      [pcs_pkg::STAT_W-1:0]         rsp_status,
   // Configuration
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [pcs_pkg::CSR_AW-1:0]         paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_EXEC     = 4'd1;
   localparam logic [3:0] ST_RD_WAIT  = 4'd2;
   localparam logic [3:0] ST_SCAN_RD  = 4'd3;
   localparam logic [3:0] ST_SCAN_CMP = 4'd4;
   localparam logic [3:0] ST_MV_RD    = 4'd5;
   localparam logic [3:0] ST_MV_WR    = 4'd6;
   localparam logic [3:0] ST_VIS_WR   = 4'd7;
   localparam logic [3:0] ST_SPL_END  = 4'd8;
   localparam logic [3:0] ST_FIN      = 4'd9;

   localparam int VD = pcs_pkg::VIS_DEPTH;
   localparam int AW = pcs_pkg::CORR_AW;
   localparam int CW = pcs_pkg::CNT_W;
   localparam int VW = pcs_pkg::VIS_CW;
   localparam int RW = pcs_pkg::REF_W;

   // Control state
   logic [3:0]                    state_ff, state_in;
   logic [CW-1:0]                 cc_ff, cc_in;
   logic [VW-1:0]                 vc_ff, vc_in;
   logic [pcs_pkg::LEN_W-1:0]     max_len_ff, max_len_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Item and work registers
   logic [pcs_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [RW-1:0]                 ref_ff, ref_in;
   logic [pcs_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [AW-1:0]                 src_ff, src_in;
   logic [AW-1:0]                 dst_ff, dst_in;
   logic [CW-1:0]                 mv_cnt_ff, mv_cnt_in;
   logic                          desc_ff, desc_in;
   logic [VW-1:0]                 take_ff, take_in;
   logic [VW-1:0]                 vptr_ff, vptr_in;
   logic [CW-1:0]                 total_ff, total_in;
   logic [RW-1:0]                 res_entry_ff, res_entry_in;
   logic [pcs_pkg::STAT_W-1:0]    res_status_ff, res_status_in;
   logic                          res_found_ff, res_found_in;

   // Output payload
   logic [pcs_pkg::LEN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [RW-1:0]                 rsp_entry_ff, rsp_entry_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [pcs_pkg::STAT_W-1:0]    rsp_status_ff, rsp_status_in;

   // Corridor memory
   logic [RW-1:0]                 corr_mem [pcs_pkg::CORR_DEPTH];
   logic [RW-1:0]                 rd_data_ff;
   logic                          mem_wr_en, mem_rd_en;
   logic [AW-1:0]                 mem_wr_addr, mem_rd_addr;
   logic [RW-1:0]                 mem_wr_data;

   // Visited cell chain
   pcs_pkg::cell_ctl_type         cell_ctl;
   logic [RW-1:0]                 cell_value [VD];
   logic [RW-1:0]                 prev_value [VD];
   logic [RW-1:0]                 next_value [VD];
   logic [VD-1:0]                 cell_valid, cell_match, prev_valid, next_valid;

   // Splice arithmetic
   logic                          hit_any;
   logic [pcs_pkg::VIS_IW-1:0]    hit_k;
   logic [CW-1:0]                 limit, req_len, avail, size, take_w;
   logic [CW:0]                   need;
   logic [CW-1:0]                 src_base;

   logic                          item_acc, csr_wr;

   assign item_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr == pcs_pkg::CSR_MAX_LEN) ? {23'd0, max_len_ff} : 32'd0;

   // Wire neighbors of the chain; cell 0 takes pushed references
   always_comb begin
      for (int k = 0; k < VD; k++) begin
         if (k == 0) begin
            prev_value[k] = ref_ff;
            prev_valid[k] = 1'b1;
         end else begin
            prev_value[k] = cell_value[k-1];
            prev_valid[k] = cell_valid[k-1];
         end
         if (k == VD - 1) begin
            next_value[k] = '0;
            next_valid[k] = 1'b0;
         end else begin
            next_value[k] = cell_value[k+1];
            next_valid[k] = cell_valid[k+1];
         end
      end
   end

   for (genvar g = 0; g < VD; g++) begin : g_cell
      pcs_visit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .prev_value (prev_value[g]),
         .prev_valid (prev_valid[g]),
         .next_value (next_value[g]),
         .next_valid (next_valid[g]),
         .probe      (rd_data_ff),
         .value      (cell_value[g]),
         .valid      (cell_valid[g]),
         .match      (cell_match[g])
      );
   end

   // Pick the oldest matching visited entry (highest cell index)
   always_comb begin
      hit_k = '0;
      for (int k = 0; k < VD; k++) begin
         if (cell_match[k]) begin
            hit_k = pcs_pkg::VIS_IW'(k);
         end
      end
      hit_any = |cell_match;
   end

   // Size the spliced corridor
   always_comb begin
      limit    = (max_len_ff > CW'(pcs_pkg::CORR_DEPTH)) ? CW'(pcs_pkg::CORR_DEPTH)
                                                          : CW'(max_len_ff);
      req_len  = CW'(hit_k) + CW'(1);
      avail    = cc_ff - CW'(ptr_ff) - CW'(1);
      take_w   = (req_len < limit) ? req_len : limit;
      need     = {1'b0, req_len} + {1'b0, avail};
      src_base = CW'(ptr_ff) + CW'(1);
      if (req_len >= limit) begin
         size = '0;
      end else if (need > {1'b0, limit}) begin
         size = limit - req_len;
      end else begin
         size = avail;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cc_in         = cc_ff;
      vc_in         = vc_ff;
      max_len_in    = max_len_ff;
      cmd_in        = cmd_ff;
      ref_in        = ref_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      mv_cnt_in     = mv_cnt_ff;
      desc_in       = desc_ff;
      take_in       = take_ff;
      vptr_in       = vptr_ff;
      total_in      = total_ff;
      res_entry_in  = res_entry_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_len_in    = rsp_len_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = ref_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ptr_ff;
      cell_ctl      = '0;

      if (csr_wr && (paddr == pcs_pkg::CSR_MAX_LEN)) begin
         max_len_in = pwdata[pcs_pkg::LEN_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_acc) begin
               cmd_in   = req_command;
               ref_in   = req_poly_ref;
               idx_in   = req_index;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_entry_in  = '0;
            res_status_in = pcs_pkg::STAT_OK;
            res_found_in  = 1'b0;
            state_in      = ST_FIN;
            unique case (cmd_ff)
               pcs_pkg::CMD_APPEND_CORR: begin
                  if (cc_ff >= CW'(pcs_pkg::CORR_DEPTH)) begin
                     res_status_in = pcs_pkg::STAT_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = cc_ff[AW-1:0];
                     cc_in       = cc_ff + CW'(1);
                  end
               end
               pcs_pkg::CMD_APPEND_VIS: begin
                  if (vc_ff >= VW'(VD)) begin
                     res_status_in = pcs_pkg::STAT_FULL;
                  end else begin
                     cell_ctl.push = 1'b1;
                     vc_in         = vc_ff + VW'(1);
                  end
               end
               pcs_pkg::CMD_SPLICE: begin
                  if ((cc_ff == '0) || (vc_ff == '0)) begin
                     vc_in          = '0;
                     cell_ctl.clear = 1'b1;
                  end else begin
                     ptr_in   = AW'(cc_ff - CW'(1));
                     state_in = ST_SCAN_RD;
                  end
               end
               pcs_pkg::CMD_READ: begin
                  if (CW'(idx_ff) < cc_ff) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AW'(idx_ff);
                     state_in    = ST_RD_WAIT;
                  end else begin
                     res_status_in = pcs_pkg::STAT_RANGE;
                  end
               end
               pcs_pkg::CMD_CLEAR: begin
                  cc_in          = '0;
                  vc_in          = '0;
                  cell_ctl.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_RD_WAIT: begin
            res_entry_in = rd_data_ff;
            state_in     = ST_FIN;
         end
         ST_SCAN_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ptr_ff;
            state_in    = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (hit_any) begin
               take_in   = VW'(take_w);
               total_in  = take_w + size;
               mv_cnt_in = size;
               vptr_in   = '0;
               desc_in   = (take_w > src_base);
               if (take_w > src_base) begin
                  src_in = AW'(CW'(ptr_ff) + size);
                  dst_in = AW'(take_w + size - CW'(1));
               end else begin
                  src_in = AW'(src_base);
                  dst_in = AW'(take_w);
               end
               if (size != '0) begin
                  state_in = ST_MV_RD;
               end else if (take_w != '0) begin
                  state_in = ST_VIS_WR;
               end else begin
                  state_in = ST_SPL_END;
               end
            end else if (ptr_ff == '0) begin
               vc_in          = '0;
               cell_ctl.clear = 1'b1;
               state_in       = ST_FIN;
            end else begin
               ptr_in   = ptr_ff - AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_MV_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = src_ff;
            state_in    = ST_MV_WR;
         end
         ST_MV_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = dst_ff;
            mem_wr_data = rd_data_ff;
            src_in      = desc_ff ? src_ff - AW'(1) : src_ff + AW'(1);
            dst_in      = desc_ff ? dst_ff - AW'(1) : dst_ff + AW'(1);
            mv_cnt_in   = mv_cnt_ff - CW'(1);
            if (mv_cnt_ff == CW'(1)) begin
               state_in = (take_ff != '0) ? ST_VIS_WR : ST_SPL_END;
            end else begin
               state_in = ST_MV_RD;
            end
         end
         ST_VIS_WR: begin
            // Drain the chain from cell 0: newest visited entry goes first
            mem_wr_en    = 1'b1;
            mem_wr_addr  = AW'(vptr_ff);
            mem_wr_data  = cell_value[0];
            cell_ctl.pop = 1'b1;
            vc_in        = vc_ff - VW'(1);
            vptr_in      = vptr_ff + VW'(1);
            if (vptr_ff == take_ff - VW'(1)) begin
               state_in = ST_SPL_END;
            end
         end
         ST_SPL_END: begin
            cc_in          = total_ff;
            vc_in          = '0;
            cell_ctl.clear = 1'b1;
            res_found_in   = 1'b1;
            state_in       = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_len_in    = pcs_pkg::LEN_W'(cc_ff);
               rsp_entry_in  = res_entry_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cc_ff        <= '0;
         vc_ff        <= '0;
         max_len_ff   <= pcs_pkg::MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         vc_ff        <= vc_in;
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ref_ff        <= ref_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      mv_cnt_ff     <= mv_cnt_in;
      desc_ff       <= desc_in;
      take_ff       <= take_in;
      vptr_ff       <= vptr_in;
      total_ff      <= total_in;
      res_entry_ff  <= res_entry_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Corridor memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         corr_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= corr_mem[mem_rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_entry       = rsp_entry_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   // Checks
   a_cc_range: assert property (@(posedge clock) disable iff (reset)
      cc_ff <= CW'(pcs_pkg::CORR_DEPTH))
      else $error("corridor count beyond depth");

   a_vc_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(vc_ff))
      else $error("visited cells disagree with visited count");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      item_acc |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_splice_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPL_END) |=> (vc_ff == '0) && (cell_valid == '0))
      else $error("visited list not emptied after splice");

endmodule
`default_nettype wire
